// ===== hw/rtl/csvt_pkg.sv =====
`default_nettype none

package csvt_pkg;

    localparam int FIELD_COUNT_BITS  = 16;
    localparam int RECORD_COUNT_BITS = 32;

    // Most tokens that one input byte can cause.
    localparam int OPS_MAX = 3;
    localparam int SLOT_W  = $clog2(OPS_MAX);

    // Bundles held between the classifier and the token engine.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_FIELD  = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;

    typedef logic [FIELD_COUNT_BITS-1:0]  t_field_cnt;
    typedef logic [RECORD_COUNT_BITS-1:0] t_record_cnt;

    // One token to be produced by the back end.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_op;

    // All tokens caused by one input word, packed to the low slots.
    typedef struct packed {
        t_op [OPS_MAX-1:0] ops;
        logic [SLOT_W-1:0] count;
    } t_bundle;

endpackage

`default_nettype wire

// ===== hw/rtl/csvt_byte_if.sv =====
`default_nettype none

interface csvt_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/csvt_tok_if.sv =====
`default_nettype none

interface csvt_tok_if;

    logic        valid;
    logic        ready;
    logic [1:0]  token_kind;
    logic [7:0]  out_byte;
    logic [15:0] field_index;
    logic [31:0] record_index;
    logic        error_code;
    logic        last_token;

    modport source (
        output valid, output token_kind, output out_byte, output field_index,
        output record_index, output error_code, output last_token, input ready
    );
    modport sink (
        input valid, input token_kind, input out_byte, input field_index,
        input record_index, input error_code, input last_token, output ready
    );

endinterface

`default_nettype wire

// ===== hw/rtl/csvt_front.sv =====
`default_nettype none

module csvt_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    csvt_byte_if.sink          i_byte,
    input  wire                i_full,
    output logic               o_push,
    output csvt_pkg::t_bundle  o_bundle
);
    import csvt_pkg::*;

    logic r_in_quotes;
    logic r_quote_pending;
    logic r_cr_pending;
    logic n_in_quotes;
    logic n_quote_pending;
    logic n_cr_pending;

    logic       accept;
    logic [3:0] cand_v;
    t_op  [3:0] cand_op;
    logic [2:0] cnt;

    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && !i_full;

    always_comb begin
        logic [7:0] c;
        logic       plain_run;
        logic       iq_eff;
        logic       rec_closed;
        c               = i_byte.data_byte;
        plain_run       = 1'b1;
        iq_eff          = r_in_quotes;
        rec_closed      = 1'b0;
        n_in_quotes     = r_in_quotes;
        n_quote_pending = r_quote_pending;
        n_cr_pending    = r_cr_pending;
        cand_v          = '0;
        cand_op         = '0;

        // Resolve what the previous word left open.
        if (r_quote_pending) begin
            n_quote_pending = 1'b0;
            if (c == CH_QUOTE) begin
                cand_v[0]  = 1'b1;
                cand_op[0] = '{kind: KIND_DATA, data: CH_QUOTE};
                plain_run  = 1'b0;
            end else begin
                n_in_quotes = 1'b0;
                iq_eff      = 1'b0;
            end
        end else if (r_cr_pending) begin
            n_cr_pending = 1'b0;
            cand_v[0]    = 1'b1;
            if (c == CH_LF) begin
                cand_op[0] = '{kind: KIND_RECORD, data: 8'h00};
                rec_closed = 1'b1;
                plain_run  = 1'b0;
            end else begin
                cand_op[0] = '{kind: KIND_DATA, data: CH_CR};
            end
        end

        // The byte itself.
        if (plain_run) begin
            if (iq_eff) begin
                if (c == CH_QUOTE) begin
                    n_quote_pending = 1'b1;
                end else begin
                    cand_v[1]  = 1'b1;
                    cand_op[1] = '{kind: KIND_DATA, data: c};
                end
            end else begin
                priority if (c == CH_QUOTE) begin
                    n_in_quotes = 1'b1;
                end else if (c == CH_COMMA) begin
                    cand_v[1]  = 1'b1;
                    cand_op[1] = '{kind: KIND_FIELD, data: 8'h00};
                end else if (c == CH_CR) begin
                    n_cr_pending = 1'b1;
                end else begin
                    cand_v[1]  = 1'b1;
                    cand_op[1] = '{kind: KIND_DATA, data: c};
                end
            end
        end

        // End of text flushes a held CR and closes any record still open.
        if (i_byte.last_byte) begin
            if (n_cr_pending) begin
                cand_v[2]  = 1'b1;
                cand_op[2] = '{kind: KIND_DATA, data: CH_CR};
            end
            n_cr_pending    = 1'b0;
            n_quote_pending = 1'b0;
            n_in_quotes     = 1'b0;
            if (!rec_closed) begin
                cand_v[3]  = 1'b1;
                cand_op[3] = '{kind: KIND_RECORD, data: 8'h00};
            end
        end
    end

    // Pack the candidates to the low slots, in order. At most three are set.
    always_comb begin
        cnt          = '0;
        o_bundle.ops = '0;
        for (int k = 0; k < 4; k++) begin
            if (cand_v[k]) begin
                o_bundle.ops[cnt[SLOT_W-1:0]] = cand_op[k];
                cnt = cnt + 3'd1;
            end
        end
        o_bundle.count = cnt[SLOT_W-1:0];
    end

    assign o_push = accept && (cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes     <= 1'b0;
            r_quote_pending <= 1'b0;
            r_cr_pending    <= 1'b0;
        end else if (accept) begin
            r_in_quotes     <= n_in_quotes;
            r_quote_pending <= n_quote_pending;
            r_cr_pending    <= n_cr_pending;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/csvt_queue.sv =====
`default_nettype none

module csvt_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  csvt_pkg::t_bundle  i_push_data,
    output logic               o_full,
    output logic               o_head_valid,
    output csvt_pkg::t_bundle  o_head,
    input  wire                i_pop
);
    import csvt_pkg::*;

    t_bundle           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/csvt_back.sv =====
`default_nettype none

module csvt_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_header_present,
    input  wire                i_head_valid,
    input  csvt_pkg::t_bundle  i_head,
    output logic               o_pop,
    csvt_tok_if.source         o_tok
);
    import csvt_pkg::*;

    logic [SLOT_W-1:0] r_slot;
    t_field_cnt        r_fields;
    t_field_cnt        r_expected;
    logic              r_expected_known;
    t_record_cnt       r_records;
    logic              r_sticky_error;

    logic              r_out_valid;
    logic [1:0]        r_kind;
    logic [7:0]        r_byte;
    t_field_cnt        r_field_idx;
    t_record_cnt       r_record_idx;
    logic              r_err;
    logic              r_last;

    t_field_cnt        n_fields;
    t_field_cnt        n_expected;
    logic              n_expected_known;
    t_record_cnt       n_records;
    logic              n_sticky_error;
    t_record_cnt       rec_sel;
    t_record_cnt       rec_out;

    logic emit;
    logic last_slot;
    t_op  op;

    assign emit      = i_head_valid && (!r_out_valid || o_tok.ready);
    assign op        = i_head.ops[r_slot];
    assign last_slot = (r_slot == (i_head.count - SLOT_W'(1)));
    assign o_pop     = emit && last_slot;

    always_comb begin
        n_fields         = r_fields;
        n_expected       = r_expected;
        n_expected_known = r_expected_known;
        n_records        = r_records;
        n_sticky_error   = r_sticky_error;
        unique case (op.kind)
            KIND_FIELD: begin
                if (r_fields != '1) begin
                    n_fields = r_fields + FIELD_COUNT_BITS'(1);
                end
            end
            KIND_RECORD: begin
                if (!r_expected_known) begin
                    n_expected_known = 1'b1;
                    n_expected       = r_fields;
                end else if (r_fields != r_expected) begin
                    n_sticky_error = 1'b1;
                end
                if (r_records != '1) begin
                    n_records = r_records + RECORD_COUNT_BITS'(1);
                end
                n_fields = '0;
            end
            default: begin
            end
        endcase
        rec_sel = (op.kind == KIND_RECORD) ? n_records : r_records;
        rec_out = (i_header_present && (rec_sel != '0))
                ? rec_sel - RECORD_COUNT_BITS'(1) : rec_sel;
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind       <= op.kind;
            r_byte       <= op.data;
            r_field_idx  <= r_fields;
            r_record_idx <= rec_out;
            r_err        <= n_sticky_error;
            r_last       <= last_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_slot           <= '0;
            r_fields         <= '0;
            r_expected       <= '0;
            r_expected_known <= 1'b0;
            r_records        <= '0;
            r_sticky_error   <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid      <= 1'b1;
                r_slot           <= last_slot ? '0 : r_slot + SLOT_W'(1);
                r_fields         <= n_fields;
                r_expected       <= n_expected;
                r_expected_known <= n_expected_known;
                r_records        <= n_records;
                r_sticky_error   <= n_sticky_error;
            end else if (o_tok.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_tok.valid        = r_out_valid;
    assign o_tok.token_kind   = r_kind;
    assign o_tok.out_byte     = r_byte;
    assign o_tok.field_index  = r_field_idx;
    assign o_tok.record_index = r_record_idx;
    assign o_tok.error_code   = r_err;
    assign o_tok.last_token   = r_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_kind != 2'd3))
        else $error("token kind out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sticky_error |=> r_sticky_error)
        else $error("sticky error cleared");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ((i_head.count != '0) && (r_slot < i_head.count)))
        else $error("slot index beyond bundle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (op.kind == KIND_RECORD)) |=> (r_fields == '0))
        else $error("field count not cleared at end of record");

endmodule

`default_nettype wire

// ===== hw/rtl/csv_stream_tokenizer.sv =====
`default_nettype none

// CSV stream tokenizer.
// The input channel i_byte carries one word per byte of CSV text: data_byte
// and last_byte, which marks the final byte of the text. The output channel
// o_tok carries one word per token: a data byte, an end of field or an end
// of record, with the field index, the count of data records so far, the
// sticky field-count error and a flag on the last token of each input byte.
// The single configuration bit, written through i_cfg_we and i_cfg_wdata
// while the block is idle, says whether the first record is a header.
// A classifier takes one byte per cycle while the queue is not full and
// turns it into a bundle of up to three tokens, which waits in a four-entry
// queue. The token engine holds the field and record counters and sends
// one token per cycle, while the receiver is ready, through an output
// register. Bytes that give at most one token flow at one per cycle when
// nothing stalls; a byte that gives two or three tokens holds the engine
// until all of them are sent. When the receiver stalls, the output register
// holds its word, the queue fills and the input is refused once it is full.
// A synchronous reset clears the quote and CR state, all counters, the
// error, the queue and the configuration bit; no clearing pass is needed.
module csv_stream_tokenizer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_wdata,
    csvt_byte_if.sink  i_byte,
    csvt_tok_if.source o_tok
);
    import csvt_pkg::*;

    // Header flag; the user writes it only while no word is in flight, unchecked.
    logic r_header_present;

    logic    push;
    logic    full;
    logic    head_valid;
    logic    pop;
    t_bundle push_data;
    t_bundle head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_present <= 1'b0;
        end else if (i_cfg_we) begin
            r_header_present <= i_cfg_wdata;
        end
    end

    // Front end: quote and CR tracking, one byte per cycle while the queue has room.
    csvt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (push_data)
    );

    // The queue lets the front keep taking bytes while tokens drain.
    csvt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Back end: counters, error check and the output register.
    csvt_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_header_present (r_header_present),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .o_pop            (pop),
        .o_tok            (o_tok)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

// Self-checking bench for the CSV stream tokenizer.
//
// Bytes of CSV text go in through the byte channel, one word per byte, and
// tokens come back through the token channel, one word per token. Every byte
// word that the block accepts is run through a bench-side model of the
// tokenizer. That model keeps its own quote, CR, field and record state. The
// tokens it predicts are queued, and each token word taken from the block is
// compared field by field with the oldest one waiting.
//
// The run opens with a short scripted text. It covers the byte extremes, a
// comma and a CR inside a quoted run, a doubled quote, a lone CR, a stray
// quote, a bare LF, an empty line that breaks the field count, a byte that
// causes three tokens, and the several ways a text can end. A few of its rows
// carry a hand-written token where the answer is obvious; every other row is
// left to the model. Four random phases follow. Each of them flips the header
// bit and uses its own mix of sender gaps and receiver stalls. Most of the
// random text is well-formed CSV with random content, and the rest is raw
// noise with stray end-of-text marks.
module testbench;

    import csvt_pkg::*;

    // Quiet cycles allowed before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Idle cycles after a drain. Any stray token the block sends in this
    // window is caught as unexpected before the bench moves on.
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_BYTES    = 100;
    localparam int REPORT_LIMIT   = 10;

    // One token as seen on the output channel.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        t_field_cnt  field;
        t_record_cnt rec;
        logic        err;
        logic        last;
    } t_token;

    // One scripted byte. Where hand_set is high, tok is the single token that
    // this byte must give, and it stands in for the model's answer.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       hand_set;
        t_token     tok;
    } t_script_row;

    typedef struct packed {
        logic       hand_set;
        t_token     tok;
    } t_answer;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_text_word;

    localparam int SCRIPT_ROWS = 29;

    t_script_row directed_script [0:SCRIPT_ROWS-1] = '{
        '{8'h61,    1'b0, 1'b1, '{KIND_DATA, 8'h61, 16'd0, 32'd0, 1'b0, 1'b1}},
        '{CH_COMMA, 1'b0, 1'b0, '0},
        '{8'hFF,    1'b0, 1'b1, '{KIND_DATA, 8'hFF, 16'd1, 32'd0, 1'b0, 1'b1}},
        '{8'h00,    1'b0, 1'b1, '{KIND_DATA, 8'h00, 16'd1, 32'd0, 1'b0, 1'b1}},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_COMMA, 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_CR,    1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{8'h78,    1'b0, 1'b0, '0},
        '{CH_CR,    1'b0, 1'b0, '0},
        '{CH_LF,    1'b0, 1'b0, '0},
        '{CH_CR,    1'b0, 1'b0, '0},
        '{8'h62,    1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_COMMA, 1'b0, 1'b0, '0},
        '{CH_LF,    1'b0, 1'b0, '0},
        '{CH_CR,    1'b0, 1'b0, '0},
        '{CH_LF,    1'b0, 1'b0, '0},
        '{CH_CR,    1'b0, 1'b0, '0},
        '{CH_LF,    1'b0, 1'b1, '{KIND_RECORD, 8'h00, 16'd0, 32'd3, 1'b1, 1'b1}},
        '{CH_CR,    1'b0, 1'b0, '0},
        '{CH_COMMA, 1'b1, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{8'h6B,    1'b1, 1'b0, '0},
        '{CH_CR,    1'b0, 1'b0, '0},
        '{CH_LF,    1'b1, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    csvt_byte_if byte_ch ();
    csvt_tok_if  tok_ch ();

    csv_stream_tokenizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (byte_ch),
        .o_tok       (tok_ch)
    );

    // Model state. It mirrors the block's, at the block's own widths.
    logic        header_cfg;
    logic        quoted       = 1'b0;
    logic        quote_wait   = 1'b0;
    logic        cr_wait      = 1'b0;
    t_field_cnt  field_cnt    = '0;
    t_field_cnt  width_ref    = '0;
    logic        width_known  = 1'b0;
    t_record_cnt records_seen = '0;
    logic        fault_sticky = 1'b0;

    t_token      byte_tokens[$];    // the tokens of the byte being modelled
    t_token      tokens_due[$];     // tokens still owed by the block
    t_answer     hand_answers[$];   // one entry per byte word put up
    t_text_word  text_words[$];     // the random text being sent

    int          src_idle_pct;
    int          snk_stall_pct;
    int          failure_count = 0;
    int          quiet_cycles  = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Tokenizer model
    // ---------------------------------------------------------------------

    // The record index leaves out the header once one record has closed.
    function void emit_token(logic [1:0] kind, logic [7:0] data, t_field_cnt field);
        t_record_cnt rec;
        rec = records_seen;
        if (header_cfg && rec != '0) begin
            rec = rec - RECORD_COUNT_BITS'(1);
        end
        byte_tokens.push_back('{kind, data, field, rec, fault_sticky, 1'b0});
    endfunction

    function void close_field();
        emit_token(KIND_FIELD, 8'h00, field_cnt);
        if (field_cnt != '1) begin
            field_cnt = field_cnt + FIELD_COUNT_BITS'(1);
        end
    endfunction

    // The first record fixes the field count. Any later record that differs
    // sets the error for good, and the record token already shows it.
    function void close_record();
        if (!width_known) begin
            width_known = 1'b1;
            width_ref   = field_cnt;
        end else if (field_cnt != width_ref) begin
            fault_sticky = 1'b1;
        end
        if (records_seen != '1) begin
            records_seen = records_seen + RECORD_COUNT_BITS'(1);
        end
        emit_token(KIND_RECORD, 8'h00, field_cnt);
        field_cnt = '0;
    endfunction

    // A byte with no quote or CR decision hanging over it.
    function void plain_char(logic [7:0] c);
        if (quoted) begin
            if (c == CH_QUOTE) begin
                quote_wait = 1'b1;
            end else begin
                emit_token(KIND_DATA, c, field_cnt);
            end
        end else if (c == CH_QUOTE) begin
            quoted = 1'b1;
        end else if (c == CH_COMMA) begin
            close_field();
        end else if (c == CH_CR) begin
            cr_wait = 1'b1;
        end else begin
            emit_token(KIND_DATA, c, field_cnt);
        end
    endfunction

    function void predict_tokens(logic [7:0] c, logic fin);
        logic closed;
        closed = 1'b0;
        byte_tokens.delete();
        if (quote_wait) begin
            // Quote followed by quote is a literal; anything else ends the run.
            quote_wait = 1'b0;
            if (c == CH_QUOTE) begin
                emit_token(KIND_DATA, CH_QUOTE, field_cnt);
            end else begin
                quoted = 1'b0;
                plain_char(c);
            end
        end else if (cr_wait) begin
            // A CR that is not followed by LF turns out to be plain data.
            cr_wait = 1'b0;
            if (c == CH_LF) begin
                close_record();
                closed = 1'b1;
            end else begin
                emit_token(KIND_DATA, CH_CR, field_cnt);
                plain_char(c);
            end
        end else begin
            plain_char(c);
        end
        // End of text flushes a held CR, drops any open run and closes the
        // record unless this very byte finished a CR LF.
        if (fin) begin
            if (cr_wait) begin
                cr_wait = 1'b0;
                emit_token(KIND_DATA, CH_CR, field_cnt);
            end
            quote_wait = 1'b0;
            quoted     = 1'b0;
            if (!closed) begin
                close_record();
            end
        end
        if (byte_tokens.size() != 0) begin
            byte_tokens[byte_tokens.size()-1].last = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Scoreboard
    // ---------------------------------------------------------------------

    function string fmt_token(t_token t);
        return $sformatf("kind=%0d byte=%02h field=%0d record=%0d err=%0d last=%0d",
                         t.kind, t.data, t.field, t.rec, t.err, t.last);
    endfunction

    // Only the first few failures are worth reading; the rest are counted.
    function void note_failure(string msg);
        if (failure_count < REPORT_LIMIT) begin
            $display("%s", msg);
        end
        failure_count++;
    endfunction

    // A byte word has been taken. The model always steps, so that its state
    // stays in line, but a scripted row with a hand-written token owes that
    // token instead of the model's.
    function void accept_byte(logic [7:0] c, logic fin);
        t_answer ans;
        predict_tokens(c, fin);
        ans = hand_answers.pop_front();
        if (ans.hand_set) begin
            tokens_due.push_back(ans.tok);
        end else begin
            foreach (byte_tokens[i]) begin
                tokens_due.push_back(byte_tokens[i]);
            end
        end
    endfunction

    function void check_token(t_token got);
        t_token want;
        if (tokens_due.size() == 0) begin
            note_failure($sformatf("unexpected token: %s", fmt_token(got)));
        end else begin
            want = tokens_due.pop_front();
            if (got.kind !== want.kind || got.data !== want.data ||
                got.field !== want.field || got.rec !== want.rec ||
                got.err !== want.err || got.last !== want.last) begin
                note_failure($sformatf("token mismatch: expected %s, got %s",
                                       fmt_token(want), fmt_token(got)));
            end
        end
    endfunction

    // Both channels are sampled at the clock edge, before any of this edge's
    // updates land, so the order of processes within the step does not count.
    always @(posedge i_clk) begin
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            accept_byte(byte_ch.data_byte, byte_ch.last_byte);
        end
        if (i_rst_n && tok_ch.valid && tok_ch.ready) begin
            check_token('{tok_ch.token_kind, tok_ch.out_byte, tok_ch.field_index,
                          tok_ch.record_index, tok_ch.error_code, tok_ch.last_token});
        end
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        tok_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Cycles in a row in which neither channel moved a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("csv_stream_tokenizer test failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    // Puts one byte word up after a random gap and holds it until taken.
    // The word stays up afterwards, so a following word can go straight out.
    task automatic send_byte(input logic [7:0] c, input logic fin,
                             input logic hand_set, input t_token tok);
        hand_answers.push_back('{hand_set, tok});
        while ($urandom_range(99) < src_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= c;
        byte_ch.last_byte <= fin;
        @(posedge i_clk);
        while (!byte_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Drops valid and waits until the block owes nothing more.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tokens_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_header(input logic value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        header_cfg   = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function void put_char(logic [7:0] c);
        text_words.push_back('{c, 1'b0});
    endfunction

    // Any byte that means nothing outside a quoted run.
    function logic [7:0] pick_plain();
        logic [7:0] c;
        c = CH_QUOTE;
        while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR) begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    // Quoted content leans on the bytes that matter: commas, CR, LF and
    // doubled quotes, mixed with anything else.
    function void put_quoted_char();
        case ($urandom_range(3))
            0: begin
                put_char(CH_QUOTE);
                put_char(CH_QUOTE);
            end
            1: put_char($urandom_range(1) ? CH_COMMA : ($urandom_range(1) ? CH_CR : CH_LF));
            default: put_char(pick_plain());
        endcase
    endfunction

    // A whole CSV text of up to four records. The field count is mostly kept
    // steady, and the closing CR LF is left off half the time.
    function void build_text();
        int n_rec;
        int n_fld;
        int fields;
        logic ragged;
        n_rec  = $urandom_range(1, 4);
        n_fld  = $urandom_range(1, 4);
        ragged = ($urandom_range(9) == 0);
        for (int r = 0; r < n_rec; r++) begin
            fields = ragged ? $urandom_range(1, 4) : n_fld;
            for (int f = 0; f < fields; f++) begin
                if (f != 0) begin
                    put_char(CH_COMMA);
                end
                case ($urandom_range(2))
                    0: ;
                    1: repeat ($urandom_range(1, 4)) put_char(pick_plain());
                    default: begin
                        put_char(CH_QUOTE);
                        repeat ($urandom_range(0, 4)) put_quoted_char();
                        put_char(CH_QUOTE);
                    end
                endcase
            end
            if (r < n_rec - 1 || $urandom_range(1) == 1) begin
                put_char(CH_CR);
                put_char(CH_LF);
            end
        end
        if (text_words.size() == 0) begin
            put_char(CH_CR);
            put_char(CH_LF);
        end
        text_words[text_words.size()-1].fin = 1'b1;
    endfunction

    // Raw bytes with the odd end-of-text mark, half of them special ones.
    function void build_noise();
        repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(1) == 1) begin
                put_char(8'($urandom_range(255)));
            end else begin
                case ($urandom_range(3))
                    0: put_char(CH_QUOTE);
                    1: put_char(CH_COMMA);
                    2: put_char(CH_CR);
                    default: put_char(CH_LF);
                endcase
            end
            text_words[text_words.size()-1].fin = ($urandom_range(7) == 0);
        end
    endfunction

    task automatic run_phase(input logic header, input int src_pct, input int snk_pct);
        int sent;
        write_header(header);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        sent = 0;
        while (sent < PHASE_BYTES) begin
            text_words.delete();
            if ($urandom_range(4) == 0) begin
                build_noise();
            end else begin
                build_text();
            end
            foreach (text_words[i]) begin
                // Now and then the sender holds off until the block is empty.
                if ($urandom_range(199) == 0) begin
                    wait_drained();
                end
                send_byte(text_words[i].data, text_words[i].fin, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= 1'b0;
        byte_ch.valid    <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.last_byte <= 1'b0;
        header_cfg        = 1'b0;
        src_idle_pct      = 0;
        snk_stall_pct     = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Scripted text, with the header bit written to its reset value.
        write_header(1'b0);
        src_idle_pct  = 25;
        snk_stall_pct = 25;
        foreach (directed_script[i]) begin
            send_byte(directed_script[i].data, directed_script[i].fin,
                      directed_script[i].hand_set, directed_script[i].tok);
        end

        run_phase(1'b1, 0, 0);
        run_phase(1'b0, 69, 0);
        run_phase(1'b1, 0, 69);
        run_phase(1'b0, 25, 25);

        // Let the last tokens out, then allow for anything stray behind them.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (failure_count == 0 && tokens_due.size() == 0) begin
            $display("csv_stream_tokenizer test passed");
        end else begin
            $display("csv_stream_tokenizer test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/csvt_pkg.sv
hw/rtl/csvt_byte_if.sv
hw/rtl/csvt_tok_if.sv
hw/rtl/csvt_front.sv
hw/rtl/csvt_queue.sv
hw/rtl/csvt_back.sv
hw/rtl/csv_stream_tokenizer.sv
tb/testbench.sv
